// ----- hw/rtl/gplpw_pkg.sv -----
// Package for the gamepad line parser with watchdog.
// Holds operation codes, token limits, neutral values and the button remap functions.
// Depends on nothing.
package gplpw_pkg;

	// Line format limits.
	localparam int MAX_DIGITS = 8;
	localparam int NUM_TOKENS = 6;

	// Operation codes of an input beat.
	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_FEED = 2'd1;
	localparam logic [1:0] OP_POLL = 2'd2;

	// Result kinds.
	localparam logic KIND_LINE  = 1'b0;
	localparam logic KIND_WATCH = 1'b1;

	// Neutral and reset values.
	localparam logic [7:0]  STICK_NEUTRAL = 8'h80;
	localparam logic [3:0]  HAT_NEUTRAL   = 4'd8;
	localparam logic [15:0] TIMEOUT_RESET = 16'd200;
	localparam logic [7:0]  CHAR_SPACE    = 8'h20;

	typedef logic [15:0] token_t;

	// Host button word to the three controller button bytes, byte 0 lowest.
	function automatic logic [23:0] map_buttons(input token_t pc);
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		b0 = {pc[7], pc[5], 2'b00, pc[2], pc[1], pc[3], pc[0]};
		b1 = {2'b00, pc[13], pc[12], pc[10], pc[11], pc[9], pc[8]};
		b2 = {pc[6], pc[4], 6'b000000};
		return {b2, b1, b0};
	endfunction

	// Hat direction to the direction bits of the third button byte.
	function automatic logic [7:0] map_hat(input logic [7:0] hat);
		logic [7:0] r;
		case (hat)
			8'd0: r = 8'h02;
			8'd1: r = 8'h02 | 8'h04;
			8'd2: r = 8'h04;
			8'd3: r = 8'h04 | 8'h01;
			8'd4: r = 8'h01;
			8'd5: r = 8'h01 | 8'h08;
			8'd6: r = 8'h08;
			8'd7: r = 8'h08 | 8'h02;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/gamepad_line_parser_with_watchdog.sv -----
// Top level of the gamepad line parser with watchdog.
// Parses hex command lines into controller state and neutralises stale input.
// Depends on gplpw_pkg.
//
// Usage:
// The input channel (in_valid / in_stall) carries one beat per line byte, watchdog
// feed or watchdog poll, selected by op. A line byte with last_byte set closes the
// line and yields one result beat (kind 0, accepted set if all six hex tokens parsed).
// A poll that finds the timeout run out while the input is not neutral forces the
// input to neutral and yields one result beat of kind 1. Feeds never yield a result.
// The output channel (out_valid / out_stall) carries the full controller state as
// it stands after the beat that caused the result.
// An accepted beat sits in the input register, and the state update loads the result
// register from it. Throughput is one beat per cycle while the receiver does not stall,
// as the state update between those registers is combinational.
// While the receiver stalls, the result register holds and the input register may
// still take one beat; further beats are stalled until the result is taken.
// The configuration channel (cfg_valid / cfg_ready) writes timeout_ms and is always
// ready; the user must write it only while the block is idle, which it does not enforce.
// Reset clears the line parser, sets the input to neutral, zeroes the press count,
// forgets any feed and sets the timeout to 200 ms.
module gamepad_line_parser_with_watchdog (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] timeout_ms,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  line_byte,
	input  logic        last_byte,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic        accepted,
	output logic [23:0] bt_buttons,
	output logic [7:0]  left_x,
	output logic [7:0]  left_y,
	output logic [7:0]  right_x,
	output logic [7:0]  right_y,
	output logic [15:0] raw_buttons,
	output logic [3:0]  raw_hat,
	output logic [31:0] press_count
);
	import gplpw_pkg::*;

	// Input register stage.
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic [31:0] now_s1;

	// Configuration and controller state.
	logic [15:0] timeout_q;
	logic [23:0] bt_q;
	logic [7:0]  stick_q [4];
	logic [15:0] raw_btn_q;
	logic [3:0]  raw_hat_q;
	logic [31:0] press_q;
	logic        was_pressed_q;
	logic [31:0] feed_time_q;
	logic        fed_q;

	// Line parser state.
	logic        line_start_q;
	logic [2:0]  tidx_q;
	logic [3:0]  dcount_q;
	token_t      tacc_q;
	logic        bad_q;
	token_t      pend_q [NUM_TOKENS];

	// Result register.
	logic        out_valid_q;
	logic        kind_q;
	logic        acc_q;
	logic [23:0] o_bt_q;
	logic [7:0]  o_stick_q [4];
	logic [15:0] o_raw_btn_q;
	logic [3:0]  o_raw_hat_q;
	logic [31:0] o_press_q;

	// Handshake control.
	logic advance;
	logic fire;
	assign advance   = !out_valid_q || !out_stall;
	assign fire      = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	// Next-state values from the item in the input register.
	logic        n_start, n_bad;
	logic [2:0]  n_tidx;
	logic [3:0]  n_dcount;
	token_t      n_tacc;
	logic        close_en;
	logic [2:0]  close_idx;
	token_t      close_val;
	logic [23:0] n_bt;
	logic [7:0]  n_stick [4];
	logic [15:0] n_raw_btn;
	logic [3:0]  n_raw_hat;
	logic [31:0] n_press;
	logic        n_was;
	logic        n_fed;
	logic [31:0] n_feed_time;
	logic        has_result;
	logic        res_kind;
	logic        res_acc;

	// Hex digit decode of the byte.
	logic       is_hex;
	logic [3:0] nib;
	always_comb begin
		is_hex = 1'b1;
		nib    = 4'd0;
		if (byte_s1 >= 8'h30 && byte_s1 <= 8'h39) begin
			nib = 4'(byte_s1 - 8'h30);
		end else if (byte_s1 >= 8'h61 && byte_s1 <= 8'h66) begin
			nib = 4'(byte_s1 - 8'h57);
		end else if (byte_s1 >= 8'h41 && byte_s1 <= 8'h46) begin
			nib = 4'(byte_s1 - 8'h37);
		end else begin
			is_hex = 1'b0;
		end
	end

	// Watchdog expiry: fed, difference below half range and at least the timeout.
	logic [31:0] diff;
	logic        expired;
	logic        not_neutral;
	assign diff    = now_s1 - feed_time_q;
	assign expired = fed_q && !diff[31] && (diff >= {16'd0, timeout_q});
	assign not_neutral = (bt_q != 24'd0) || (stick_q[0] != STICK_NEUTRAL) ||
		(stick_q[1] != STICK_NEUTRAL) || (stick_q[2] != STICK_NEUTRAL) ||
		(stick_q[3] != STICK_NEUTRAL);

	// Applied line values; the sixth token may be closing in this same beat.
	token_t      tok5;
	logic [7:0]  hat8;
	logic [23:0] line_bt;
	assign tok5    = (close_en && close_idx == 3'(NUM_TOKENS - 1)) ? close_val
		: pend_q[NUM_TOKENS - 1];
	assign hat8    = pend_q[1][7:0];
	assign line_bt = map_buttons(pend_q[0]) | {map_hat(hat8), 16'd0};

	// Parser, line completion and watchdog for one beat.
	always_comb begin
		n_start     = line_start_q;
		n_bad       = bad_q;
		n_tidx      = tidx_q;
		n_dcount    = dcount_q;
		n_tacc      = tacc_q;
		close_en    = 1'b0;
		close_idx   = tidx_q;
		close_val   = tacc_q;
		n_bt        = bt_q;
		n_stick     = stick_q;
		n_raw_btn   = raw_btn_q;
		n_raw_hat   = raw_hat_q;
		n_press     = press_q;
		n_was       = was_pressed_q;
		n_fed       = fed_q;
		n_feed_time = feed_time_q;
		has_result  = 1'b0;
		res_kind    = KIND_LINE;
		res_acc     = 1'b0;
		unique case (op_s1)
			OP_BYTE: begin
				// Take the byte into the current token; the first byte of a line is skipped.
				if (line_start_q) begin
					n_start = 1'b0;
				end else if (!bad_q && tidx_q < 3'(NUM_TOKENS)) begin
					if (byte_s1 == CHAR_SPACE) begin
						if (dcount_q != 4'd0) begin
							close_en = 1'b1;
						end
					end else if (!is_hex || dcount_q >= 4'(MAX_DIGITS)) begin
						n_bad = 1'b1;
					end else begin
						n_tacc   = {tacc_q[11:0], nib};
						n_dcount = dcount_q + 4'd1;
					end
				end
				// The final byte closes any open token unless the line is bad.
				if (last_s1 && !n_bad && n_tidx < 3'(NUM_TOKENS) && n_dcount != 4'd0) begin
					close_en  = 1'b1;
					close_val = n_tacc;
				end
				if (close_en) begin
					n_tidx   = tidx_q + 3'd1;
					n_dcount = 4'd0;
					n_tacc   = '0;
				end
				// Line end: apply on success, then start a fresh line.
				if (last_s1) begin
					res_acc    = !n_bad && n_tidx == 3'(NUM_TOKENS);
					has_result = 1'b1;
					if (res_acc) begin
						n_bt       = line_bt;
						n_stick[0] = pend_q[2][7:0];
						n_stick[1] = pend_q[3][7:0];
						n_stick[2] = pend_q[4][7:0];
						n_stick[3] = tok5[7:0];
						n_raw_btn  = pend_q[0];
						n_raw_hat  = (hat8 > 8'd8) ? HAT_NEUTRAL : hat8[3:0];
						if (line_bt != 24'd0 && !was_pressed_q) begin
							n_press = press_q + 32'd1;
							n_was   = 1'b1;
						end else if (line_bt == 24'd0) begin
							n_was = 1'b0;
						end
					end
					n_start  = 1'b1;
					n_tidx   = 3'd0;
					n_dcount = 4'd0;
					n_tacc   = '0;
					n_bad    = 1'b0;
				end
			end
			OP_FEED: begin
				n_feed_time = now_s1;
				n_fed       = 1'b1;
			end
			OP_POLL: begin
				if (expired && not_neutral) begin
					n_bt       = 24'd0;
					n_stick[0] = STICK_NEUTRAL;
					n_stick[1] = STICK_NEUTRAL;
					n_stick[2] = STICK_NEUTRAL;
					n_stick[3] = STICK_NEUTRAL;
					n_raw_btn  = 16'd0;
					n_raw_hat  = HAT_NEUTRAL;
					n_was      = 1'b0;
					has_result = 1'b1;
					res_kind   = KIND_WATCH;
				end
			end
			default: begin
			end
		endcase
	end

	// Input register: control bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register: payload.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= op;
			byte_s1 <= line_byte;
			last_s1 <= last_byte;
			now_s1  <= now_ms;
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= timeout_ms;
		end
	end

	// Controller, watchdog and parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bt_q          <= 24'd0;
			stick_q       <= '{default: STICK_NEUTRAL};
			raw_btn_q     <= 16'd0;
			raw_hat_q     <= HAT_NEUTRAL;
			press_q       <= 32'd0;
			was_pressed_q <= 1'b0;
			feed_time_q   <= 32'd0;
			fed_q         <= 1'b0;
			line_start_q  <= 1'b1;
			tidx_q        <= 3'd0;
			dcount_q      <= 4'd0;
			tacc_q        <= '0;
			bad_q         <= 1'b0;
		end else if (fire) begin
			bt_q          <= n_bt;
			stick_q       <= n_stick;
			raw_btn_q     <= n_raw_btn;
			raw_hat_q     <= n_raw_hat;
			press_q       <= n_press;
			was_pressed_q <= n_was;
			feed_time_q   <= n_feed_time;
			fed_q         <= n_fed;
			line_start_q  <= n_start;
			tidx_q        <= n_tidx;
			dcount_q      <= n_dcount;
			tacc_q        <= n_tacc;
			bad_q         <= n_bad;
		end
	end

	// Token store; an entry is always written earlier in the line than it is read.
	always_ff @(posedge clk) begin
		if (fire && close_en && close_idx < 3'(NUM_TOKENS)) begin
			pend_q[close_idx] <= close_val;
		end
	end

	// Result register: control bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && has_result;
		end
	end

	// Result register: payload.
	always_ff @(posedge clk) begin
		if (fire && has_result) begin
			kind_q      <= res_kind;
			acc_q       <= res_acc;
			o_bt_q      <= n_bt;
			o_stick_q   <= n_stick;
			o_raw_btn_q <= n_raw_btn;
			o_raw_hat_q <= n_raw_hat;
			o_press_q   <= n_press;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign accepted    = acc_q;
	assign bt_buttons  = o_bt_q;
	assign left_x      = o_stick_q[0];
	assign left_y      = o_stick_q[1];
	assign right_x     = o_stick_q[2];
	assign right_y     = o_stick_q[3];
	assign raw_buttons = o_raw_btn_q;
	assign raw_hat     = o_raw_hat_q;
	assign press_count = o_press_q;

	// The input side is only held back while the input register is occupied.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	// The token index never runs past the token count.
	a_tidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		tidx_q <= 3'(NUM_TOKENS))
		else $error("token index out of range");

	// The press count moves by at most one per cycle.
	a_press_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (press_q == $past(press_q) || press_q == $past(press_q) + 32'd1))
		else $error("press count jumped");

	// A watchdog result reports neutral input and no accepted line.
	a_watch_neutral: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_WATCH) |->
		(!accepted && bt_buttons == 24'd0 && raw_hat == HAT_NEUTRAL))
		else $error("watchdog result not neutral");

endmodule
